>>> sv/mmpd_pkg.sv
// Shared constants, register indexes and codes for the multi-motor PD speed controller.
package mmpd_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int SEL_W      = 2;
  localparam int MAX_SEL    = 1 << SEL_W;

  localparam int SPEED_W = 16;
  localparam int PWM_W   = 10;
  localparam int DEN_W   = 15;
  localparam int GAIN_W  = 8;
  localparam int DRIVE_W = 8;
  localparam int CMP_W   = 10;
  localparam int DIR_W   = 2;
  localparam int DBYTE_W = DIR_W * MAX_SEL;

  // Shared multiplier operand widths and product width kept.
  localparam int MUL_A_W   = SPEED_W + 1;
  localparam int MUL_B_W   = PWM_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int PROD_W    = 27;
  localparam int MAG_W     = PROD_W - 1;
  localparam int DIV_STEPS = MAG_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_PULLBACK  = 3'd5;

  localparam logic [PWM_W-1:0]  RST_PWM_SCALE      = 10'd100;
  localparam logic [DEN_W-1:0]  RST_SPEED_SCALE    = 15'd100;
  localparam logic [GAIN_W-1:0] RST_GAIN_P         = 8'd1;
  localparam logic [GAIN_W-1:0] RST_GAIN_D         = 8'd1;
  localparam logic [DEN_W-1:0]  RST_JUMP_THRESHOLD = 15'd100;
  localparam logic [DEN_W-1:0]  RST_JUMP_PULLBACK  = 15'd50;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd2;

  localparam logic signed [SPEED_W-1:0] DRIVE_MAX = 16'sd100;
  localparam logic signed [SPEED_W-1:0] DRIVE_MIN = -16'sd100;

endpackage

>>> sv/mmpd_if.sv
// Valid/ready channel interfaces for input items and result items.
interface mmpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_select;
  logic signed [15:0] measured_speed;
  logic signed [15:0] target_speed;

  modport source (output valid, motor_select, measured_speed, target_speed, input ready);
  modport sink   (input valid, motor_select, measured_speed, target_speed, output ready);
endinterface

interface mmpd_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] drive;
  logic [1:0]        direction;
  logic [9:0]        compare_value;
  logic [7:0]        direction_byte;
  logic signed [15:0] error_value;

  modport source (output valid, drive, direction, compare_value, direction_byte, error_value,
                  input ready);
  modport sink   (input valid, drive, direction, compare_value, direction_byte, error_value,
                  output ready);
endinterface

>>> sv/multi_motor_pd_speed_controller.sv
// Top level: four-motor PD speed controller with setpoint feedforward.
//
//   channel   dir  beat contents
//   --------  ---  ---------------------------------------------------------------
//   items_i   in   motor_select, measured_speed, target_speed
//   results_o out  drive, direction, compare_value, direction_byte, error_value
//   cfg_*     in   write enable, register index, write data (no handshake)
//
// For each beat, a serial divider that retires two quotient bits a cycle runs
// twice (error, then feedforward), and one shared 17x11 multiplier is used in
// four separate steps.
// items_i.ready is high only while the sequencer is idle.
// A result waits in the output register until taken; the next beat may be
// accepted meanwhile, and the sequencer holds at its last step if the output
// register is still full. Reset is asynchronous, active low; it restores the
// register defaults and clears the per-motor history.
module multi_motor_pd_speed_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  mmpd_in_if.sink                             items_i,
  mmpd_out_if.source                          results_o
);
  import mmpd_pkg::*;

  // Sequencer codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;  // (target - measured) * pwm_scale
  localparam logic [3:0] S_DST1 = 4'd2;  // start error divide, apply jump pull-back
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;  // adjusted target * pwm_scale
  localparam logic [3:0] S_DST2 = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_MULP = 4'd7;  // gain_p * error
  localparam logic [3:0] S_MULD = 4'd8;  // gain_d * error change, start sum
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // Configuration registers.
  logic [PWM_W-1:0]  pwm_scale_q, pwm_scale_d;
  logic [DEN_W-1:0]  speed_scale_q, speed_scale_d;
  logic [GAIN_W-1:0] gain_p_q, gain_p_d;
  logic [GAIN_W-1:0] gain_d_q, gain_d_d;
  logic [DEN_W-1:0]  jump_thr_q, jump_thr_d;
  logic [DEN_W-1:0]  jump_pull_q, jump_pull_d;

  // Per-motor history.
  logic signed [SPEED_W-1:0] last_err_q [NUM_MOTORS];
  logic signed [SPEED_W-1:0] last_err_d [NUM_MOTORS];
  logic signed [SPEED_W-1:0] last_tgt_q [NUM_MOTORS];
  logic signed [SPEED_W-1:0] last_tgt_d [NUM_MOTORS];
  logic [DIR_W-1:0]          mdir_q [NUM_MOTORS];
  logic [DIR_W-1:0]          mdir_d [NUM_MOTORS];

  // Sequencer and working registers.
  logic [3:0]                state_q, state_d;
  logic [SEL_W-1:0]          sel_q, sel_d;
  logic signed [SPEED_W-1:0] meas_q, meas_d;
  logic signed [SPEED_W-1:0] tgt_q, tgt_d;
  logic signed [SPEED_W-1:0] prev_t_q, prev_t_d;
  logic signed [SPEED_W-1:0] prev_e_q, prev_e_d;
  logic signed [SPEED_W-1:0] err_q, err_d;
  logic signed [SPEED_W-1:0] ff_q, ff_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [SPEED_W-1:0]        acc_q, acc_d;

  // Output register.
  logic                      ovalid_q, ovalid_d;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic [DIR_W-1:0]          dir_q, dir_d;
  logic [CMP_W-1:0]          cmp_q, cmp_d;
  logic [DBYTE_W-1:0]        dbyte_q, dbyte_d;
  logic signed [SPEED_W-1:0] errv_q, errv_d;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Divider hookup.
  logic                     div_start;
  logic                     div_done;
  logic signed [PROD_W-1:0] div_quo;

  // Jump test and result shaping.
  logic signed [MUL_A_W-1:0] jump_diff;
  logic signed [MUL_A_W-1:0] thr_pos;
  logic signed [MUL_A_W-1:0] thr_neg;
  logic signed [SPEED_W-1:0] tgt_adj;
  logic signed [SPEED_W-1:0] sum_s;
  logic signed [SPEED_W-1:0] drive_w;
  logic [DIR_W-1:0]          dir_w;
  logic [DRIVE_W-1:0]        drive_mag;
  logic [CMP_W-1:0]          mag_ext;
  logic [DIR_W-1:0]          dirs_next [MAX_SEL];
  logic [DBYTE_W-1:0]        packed_w;
  logic                      out_free;
  logic                      in_acc;

  mmpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (speed_scale_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign items_i.ready = (state_q == S_IDLE);
  assign in_acc        = items_i.valid && items_i.ready;
  assign out_free      = !ovalid_q || results_o.ready;
  assign div_start     = (state_q == S_DST1) || (state_q == S_DST2);

  // Steer the shared multiplier by step.
  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = {tgt_q[SPEED_W-1], tgt_q} - {meas_q[SPEED_W-1], meas_q};
        mul_b = signed'({1'b0, pwm_scale_q});
      end
      S_MUL2: begin
        mul_a = {tgt_q[SPEED_W-1], tgt_q};
        mul_b = signed'({1'b0, pwm_scale_q});
      end
      S_MULP: begin
        mul_a = {err_q[SPEED_W-1], err_q};
        mul_b = {{(MUL_B_W-GAIN_W){gain_p_q[GAIN_W-1]}}, gain_p_q};
      end
      S_MULD: begin
        mul_a = {err_q[SPEED_W-1], err_q} - {prev_e_q[SPEED_W-1], prev_e_q};
        mul_b = {{(MUL_B_W-GAIN_W){gain_d_q[GAIN_W-1]}}, gain_d_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Jump pull-back: move the target back toward the stored one on a large step.
  always_comb begin
    jump_diff = {tgt_q[SPEED_W-1], tgt_q} - {prev_t_q[SPEED_W-1], prev_t_q};
    thr_pos   = signed'({2'b00, jump_thr_q});
    thr_neg   = -thr_pos;
    if (jump_diff >= thr_pos) begin
      tgt_adj = tgt_q - signed'({1'b0, jump_pull_q});
    end else if (jump_diff <= thr_neg) begin
      tgt_adj = tgt_q + signed'({1'b0, jump_pull_q});
    end else begin
      tgt_adj = tgt_q;
    end
  end

  // Clamp the wrapped sum and derive direction, compare value and packed byte.
  always_comb begin
    sum_s = signed'(acc_q);
    if (sum_s <= DRIVE_MIN) begin
      drive_w = DRIVE_MIN;
    end else if (sum_s >= DRIVE_MAX) begin
      drive_w = DRIVE_MAX;
    end else begin
      drive_w = sum_s;
    end
    if (drive_w > 0) begin
      dir_w = DIR_FWD;
    end else if (drive_w < 0) begin
      dir_w = DIR_REV;
    end else begin
      dir_w = DIR_STOP;
    end
    drive_mag = drive_w[SPEED_W-1] ? (~drive_w[DRIVE_W-1:0] + 1'b1) : drive_w[DRIVE_W-1:0];
    mag_ext   = {{(CMP_W-DRIVE_W){1'b0}}, drive_mag};
    for (int i = 0; i < MAX_SEL; i++) begin
      if (i < NUM_MOTORS) begin
        dirs_next[i] = (sel_q == SEL_W'(i)) ? dir_w : mdir_q[i];
      end else begin
        dirs_next[i] = DIR_STOP;
      end
    end
    for (int i = 0; i < MAX_SEL; i++) begin
      packed_w[DBYTE_W-1-DIR_W*i -: DIR_W] = dirs_next[i];
    end
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    meas_d        = meas_q;
    tgt_d         = tgt_q;
    prev_t_d      = prev_t_q;
    prev_e_d      = prev_e_q;
    err_d         = err_q;
    ff_d          = ff_q;
    prod_d        = prod_q;
    acc_d         = acc_q;
    last_err_d    = last_err_q;
    last_tgt_d    = last_tgt_q;
    mdir_d        = mdir_q;
    ovalid_d      = ovalid_q && !results_o.ready;
    drive_d       = drive_q;
    dir_d         = dir_q;
    cmp_d         = cmp_q;
    dbyte_d       = dbyte_q;
    errv_d        = errv_q;

    // Configuration writes; keep only each register's width.
    pwm_scale_d   = pwm_scale_q;
    speed_scale_d = speed_scale_q;
    gain_p_d      = gain_p_q;
    gain_d_d      = gain_d_q;
    jump_thr_d    = jump_thr_q;
    jump_pull_d   = jump_pull_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_SCALE:      pwm_scale_d   = cfg_wdata_i[PWM_W-1:0];
        CFG_SPEED_SCALE:    speed_scale_d = cfg_wdata_i[DEN_W-1:0];
        CFG_GAIN_P:         gain_p_d      = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D:         gain_d_d      = cfg_wdata_i[GAIN_W-1:0];
        CFG_JUMP_THRESHOLD: jump_thr_d    = cfg_wdata_i[DEN_W-1:0];
        CFG_JUMP_PULLBACK:  jump_pull_d   = cfg_wdata_i[DEN_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sel_d    = items_i.motor_select;
          meas_d   = items_i.measured_speed;
          tgt_d    = items_i.target_speed;
          // Unused motor slots read as zero history.
          prev_t_d = '0;
          prev_e_d = '0;
          for (int i = 0; i < NUM_MOTORS; i++) begin
            if (items_i.motor_select == SEL_W'(i)) begin
              prev_t_d = last_tgt_q[i];
              prev_e_d = last_err_q[i];
            end
          end
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_DST1;
      end
      S_DST1: begin
        tgt_d   = tgt_adj;
        state_d = S_DIV1;
      end
      S_DIV1: begin
        if (div_done) begin
          err_d   = div_quo[SPEED_W-1:0];
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_DST2;
      end
      S_DST2: begin
        state_d = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          ff_d    = div_quo[SPEED_W-1:0];
          state_d = S_MULP;
        end
      end
      S_MULP: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_MULD;
      end
      S_MULD: begin
        // Only the low 16 bits of the sum survive, so add modulo 2^16.
        acc_d   = ff_q + prod_q[SPEED_W-1:0];
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = acc_q + prod_q[SPEED_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register can take the beat.
        if (out_free) begin
          for (int i = 0; i < NUM_MOTORS; i++) begin
            if (sel_q == SEL_W'(i)) begin
              last_tgt_d[i] = tgt_q;
              last_err_d[i] = err_q;
              mdir_d[i]     = dir_w;
            end
          end
          ovalid_d = 1'b1;
          drive_d  = drive_w[DRIVE_W-1:0];
          dir_d    = dir_w;
          cmp_d    = (mag_ext << 3) + (mag_ext << 1);
          dbyte_d  = packed_w;
          errv_d   = err_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ovalid_q      <= 1'b0;
      pwm_scale_q   <= RST_PWM_SCALE;
      speed_scale_q <= RST_SPEED_SCALE;
      gain_p_q      <= RST_GAIN_P;
      gain_d_q      <= RST_GAIN_D;
      jump_thr_q    <= RST_JUMP_THRESHOLD;
      jump_pull_q   <= RST_JUMP_PULLBACK;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        last_err_q[i] <= '0;
        last_tgt_q[i] <= '0;
        mdir_q[i]     <= DIR_STOP;
      end
    end else begin
      state_q       <= state_d;
      ovalid_q      <= ovalid_d;
      pwm_scale_q   <= pwm_scale_d;
      speed_scale_q <= speed_scale_d;
      gain_p_q      <= gain_p_d;
      gain_d_q      <= gain_d_d;
      jump_thr_q    <= jump_thr_d;
      jump_pull_q   <= jump_pull_d;
      last_err_q    <= last_err_d;
      last_tgt_q    <= last_tgt_d;
      mdir_q        <= mdir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    meas_q   <= meas_d;
    tgt_q    <= tgt_d;
    prev_t_q <= prev_t_d;
    prev_e_q <= prev_e_d;
    err_q    <= err_d;
    ff_q     <= ff_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    drive_q  <= drive_d;
    dir_q    <= dir_d;
    cmp_q    <= cmp_d;
    dbyte_q  <= dbyte_d;
    errv_q   <= errv_d;
  end

  assign results_o.valid          = ovalid_q;
  assign results_o.drive          = drive_q;
  assign results_o.direction      = dir_q;
  assign results_o.compare_value  = cmp_q;
  assign results_o.direction_byte = dbyte_q;
  assign results_o.error_value    = errv_q;

endmodule

>>> sv/mmpd_div.sv
// Serial signed divider, two quotient bits per cycle, truncating toward zero.
module mmpd_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [mmpd_pkg::PROD_W-1:0]    dividend_i,
  input  logic        [mmpd_pkg::DEN_W-1:0]     divisor_i,
  output logic                                  done_o,
  output logic signed [mmpd_pkg::PROD_W-1:0]    quotient_o
);
  import mmpd_pkg::*;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     num_q, num_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic                 neg_q, neg_d;
  logic                 zero_q, zero_d;

  logic [PROD_W-1:0] abs_full;
  logic [DEN_W:0]    r1, r2, r1_sub, r2_sub;
  logic              ge1, ge2;
  logic [DEN_W-1:0]  r1s, r2s;
  logic [PROD_W-1:0] mag_ext;

  assign abs_full = dividend_i[PROD_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // Two restoring steps per cycle.
  always_comb begin
    r1     = {rem_q, num_q[MAG_W-1]};
    ge1    = (r1 >= {1'b0, den_q});
    r1_sub = r1 - {1'b0, den_q};
    r1s    = ge1 ? r1_sub[DEN_W-1:0] : r1[DEN_W-1:0];
    r2     = {r1s, num_q[MAG_W-2]};
    ge2    = (r2 >= {1'b0, den_q});
    r2_sub = r2 - {1'b0, den_q};
    r2s    = ge2 ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = abs_full[MAG_W-1:0];
      rem_d  = '0;
      den_d  = divisor_i;
      neg_d  = dividend_i[PROD_W-1];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      num_d = {num_q[MAG_W-3:0], ge1, ge2};
      rem_d = r2s;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign mag_ext    = {1'b0, num_q};
  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : (neg_q ? signed'(~mag_ext + 1'b1) : signed'(mag_ext));

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the four-motor PD speed controller.
`timescale 1ns / 1ps

module tb_top;
  import mmpd_pkg::*;

  // Keep each run bounded; the clock period is 12 ns.
  localparam int  HOLD_OFF_CYCLES = 400;
  localparam int  DRAIN_CYCLES    = 60;
  localparam time RUN_LIMIT       = 5_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mmpd_in_if  items ();
  mmpd_out_if results ();

  multi_motor_pd_speed_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .items_i     (items),
    .results_o   (results)
  );

  // One result beat as the block should present it.
  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic [DIR_W-1:0]          direction;
    logic [CMP_W-1:0]          compare_value;
    logic [DBYTE_W-1:0]        direction_byte;
    logic signed [SPEED_W-1:0] error_value;
  } drive_result_t;

  // Shadow of the controller: register file, per-motor history and the queue of
  // drive results still owed by the block.
  class speed_loop_scoreboard;
    logic [PWM_W-1:0]          pwm_scale;
    logic [DEN_W-1:0]          speed_scale;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [DEN_W-1:0]          jump_thr;
    logic [DEN_W-1:0]          jump_pull;
    logic signed [SPEED_W-1:0] last_err [MAX_SEL];
    logic signed [SPEED_W-1:0] last_tgt [MAX_SEL];
    logic [DIR_W-1:0]          motor_dir [MAX_SEL];
    drive_result_t             owed [$];
    int                        faults;

    function new();
      pwm_scale   = RST_PWM_SCALE;
      speed_scale = RST_SPEED_SCALE;
      gain_p      = RST_GAIN_P;
      gain_d      = RST_GAIN_D;
      jump_thr    = RST_JUMP_THRESHOLD;
      jump_pull   = RST_JUMP_PULLBACK;
      faults      = 0;
      for (int i = 0; i < MAX_SEL; i++) begin
        last_err[i]  = '0;
        last_tgt[i]  = '0;
        motor_dir[i] = DIR_STOP;
      end
    endfunction

    // Keep only the register's own width, as the hardware does.
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PWM_SCALE:      pwm_scale   = data[PWM_W-1:0];
        CFG_SPEED_SCALE:    speed_scale = data[DEN_W-1:0];
        CFG_GAIN_P:         gain_p      = data[GAIN_W-1:0];
        CFG_GAIN_D:         gain_d      = data[GAIN_W-1:0];
        CFG_JUMP_THRESHOLD: jump_thr    = data[DEN_W-1:0];
        CFG_JUMP_PULLBACK:  jump_pull   = data[DEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Speed-to-PWM ratio, quotient truncated toward zero; a zero denominator gives zero.
    function longint speed_to_pwm(longint v);
      if (speed_scale == '0) return 0;
      return (v * longint'(pwm_scale)) / longint'(speed_scale);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_item(logic [SEL_W-1:0] sel, logic signed [SPEED_W-1:0] meas,
                            logic signed [SPEED_W-1:0] tgt_in);
      logic signed [SPEED_W-1:0] prev_t, prev_e, err, tgt, sum16;
      longint                    diff, sum;
      int                        drv;
      bit                        in_use;
      drive_result_t             r;
      in_use = (sel < NUM_MOTORS);
      prev_t = in_use ? last_tgt[sel] : '0;
      prev_e = in_use ? last_err[sel] : '0;
      err    = 16'(speed_to_pwm(longint'(tgt_in) - longint'(meas)));

      // Pull a large setpoint jump back toward the previous target; wrap at 16 bits.
      diff = longint'(tgt_in) - longint'(prev_t);
      if (diff >= longint'(jump_thr))
        tgt = 16'(longint'(tgt_in) - longint'(jump_pull));
      else if (diff <= -longint'(jump_thr))
        tgt = 16'(longint'(tgt_in) + longint'(jump_pull));
      else
        tgt = tgt_in;

      sum = speed_to_pwm(longint'(tgt)) + longint'(gain_p) * longint'(err)
          + longint'(gain_d) * (longint'(err) - longint'(prev_e));
      sum16 = 16'(sum);
      drv   = sum16;
      if (drv <= -100) drv = -100;
      else if (drv >= 100) drv = 100;

      r.drive         = 8'(drv);
      r.direction     = (drv > 0) ? DIR_FWD : (drv < 0) ? DIR_REV : DIR_STOP;
      r.compare_value = 10'(((drv < 0) ? -drv : drv) * 10);
      r.error_value   = err;
      if (in_use) begin
        last_tgt[sel]  = tgt;
        last_err[sel]  = err;
        motor_dir[sel] = r.direction;
      end
      r.direction_byte = '0;
      for (int i = 0; i < NUM_MOTORS; i++)
        r.direction_byte[DBYTE_W-1-DIR_W*i -: DIR_W] = motor_dir[i];
      owed.push_back(r);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result beat drive=%0d err=%0d", $realtime, got.drive,
                   got.error_value);
        return;
      end
      want = owed.pop_front();
      if (got.drive !== want.drive || got.direction !== want.direction ||
          got.compare_value !== want.compare_value ||
          got.direction_byte !== want.direction_byte ||
          got.error_value !== want.error_value) begin
        faults++;
        if (faults <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected drive=%0d dir=%0d cmp=%0d dbyte=%h err=%0d", want.drive,
                   want.direction, want.compare_value, want.direction_byte, want.error_value);
          $display("  actual   drive=%0d dir=%0d cmp=%0d dbyte=%h err=%0d", got.drive,
                   got.direction, got.compare_value, got.direction_byte, got.error_value);
        end
      end
    endfunction
  endclass

  speed_loop_scoreboard sb = new();

  bit idle_on  = 1'b1;  // random idle bursts on both channels
  bit hold_req = 1'b0;  // ask the result side for one long hold-off

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Sample both channels at the rising edge; a beat moves when valid and ready are high.
  always @(posedge clk_i) begin
    drive_result_t got;
    if (rst_ni) begin
      if (results.valid && results.ready) begin
        got.drive          = results.drive;
        got.direction      = results.direction;
        got.compare_value  = results.compare_value;
        got.direction_byte = results.direction_byte;
        got.error_value    = results.error_value;
        sb.check_result(got);
      end
      if (items.valid && items.ready)
        sb.note_item(items.motor_select, items.measured_speed, items.target_speed);
    end
  end

  // Result side: stall in short random bursts, take beats in longer runs, and once
  // hold ready low long enough that the output register fills and the input stalls.
  initial begin
    results.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req      = 1'b0;
        results.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        results.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end else begin
        results.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  // Offer one beat and hold it until accepted. Call at a falling edge; return at
  // the falling edge after acceptance with valid still high, so that a following
  // beat replaces the payload without a drop in valid.
  task automatic send_item(input logic [SEL_W-1:0] sel, input logic signed [SPEED_W-1:0] meas,
                           input logic signed [SPEED_W-1:0] tgt);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      items.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    items.valid          = 1'b1;
    items.motor_select   = sel;
    items.measured_speed = meas;
    items.target_speed   = tgt;
    @(posedge clk_i);
    while (!items.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and let the block drain before touching its registers.
  task automatic wait_idle();
    items.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    sb.set_register(idx, data);
    @(negedge clk_i);
  endtask

  // Write every register; values wider than a register are trimmed by the block.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] pwm, spd, kp, kd, thr, pull);
    write_reg(CFG_PWM_SCALE, pwm);
    write_reg(CFG_SPEED_SCALE, spd);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_JUMP_THRESHOLD, thr);
    write_reg(CFG_JUMP_PULLBACK, pull);
    cfg_we = 1'b0;
  endtask

  // Random beats: mostly small speeds and targets right at the jump threshold, so
  // the drive leaves the clamp and the pull-back fires both ways; the rest full range.
  task automatic run_random(input int count);
    logic [SEL_W-1:0]          sel;
    logic signed [SPEED_W-1:0] meas, tgt;
    int                        base, step;
    repeat (count) begin
      sel  = SEL_W'($urandom_range(0, MAX_SEL - 1));
      base = sb.last_tgt[sel];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: tgt = 16'(int'($urandom_range(0, 400)) - 200);
        4, 5, 6: begin
          step = int'(sb.jump_thr) + int'($urandom_range(0, 2)) - 1;
          tgt  = 16'($urandom_range(0, 1) ? base + step : base - step);
        end
        default: tgt = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0, 1: meas = 16'(int'(tgt) + int'($urandom_range(0, 60)) - 30);
        2:    meas = 16'(int'($urandom_range(0, 400)) - 200);
        default: meas = 16'($urandom);
      endcase
      send_item(sel, meas, tgt);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    items.valid          = 1'b0;
    items.motor_select   = '0;
    items.measured_speed = '0;
    items.target_speed   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: zero input, threshold edges both ways, speed extremes.
    send_item(2'd0, 16'sd0, 16'sd0);
    send_item(2'd1, 16'sd0, 16'sd99);
    send_item(2'd2, 16'sd0, 16'sd100);
    send_item(2'd3, 16'sd0, -16'sd100);
    send_item(2'd0, -16'sd32768, 16'sd32767);
    send_item(2'd1, 16'sd32767, -16'sd32768);
    send_item(2'd2, 16'sd5, 16'sd2);
    send_item(2'd3, 16'sd3, 16'sd3);
    send_item(2'd0, -16'sd32768, -16'sd32768);
    send_item(2'd1, 16'sd32767, 16'sd32767);
    run_random(60);
    hold_req = 1'b1;
    run_random(60);
    wait_idle();

    // Pwm scale 1000, unit denominator, gain extremes, zero threshold, full pull-back.
    // Upper bits of the pwm and gain data are set to check that those registers keep their width.
    load_settings(15'h7FE8, 15'd1, 15'h7F7F, 15'h0180, 15'd0, 15'd32767);
    // Walk motor 0 into an adjusted target that wraps down, then one that wraps up.
    send_item(2'd0, 16'sd0, 16'sd32767);
    send_item(2'd0, 16'sd0, 16'sd5);
    send_item(2'd0, 16'sd0, -16'sd32000);
    send_item(2'd0, 16'sd0, 16'sd100);
    run_random(80);
    wait_idle();

    // Zero denominator: error and feedforward drop out, only the error change acts.
    load_settings(15'h0400, 15'd0, 15'h0080, 15'd127, 15'd32767, 15'd0);
    send_item(2'd2, -16'sd32768, 16'sd32767);
    send_item(2'd3, 16'sd1, 16'sd0);
    run_random(40);
    wait_idle();

    load_settings(15'd1, 15'd32767, 15'h00FF, 15'd0, 15'd32767, 15'd0);
    run_random(80);
    wait_idle();

    load_settings(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                  15'($urandom_range(0, 400)), 15'($urandom_range(0, 400)));
    run_random(70);
    // Finish at full rate on both sides.
    idle_on = 1'b0;
    run_random(60);

    items.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.faults == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

>>> files.f
sv/mmpd_pkg.sv
sv/mmpd_if.sv
sv/mmpd_div.sv
sv/multi_motor_pd_speed_controller.sv
test/tb_top.sv
